>>> hdl/pta_pkg.sv
package pta_pkg;

	localparam int VALUE_BITS = 24;
	localparam int TIME_BITS  = 24;
	localparam int FRAC_BITS  = 17;
	localparam int CHANNELS   = 6;

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic [TIME_BITS-1:0]         tim_t;
	typedef logic [FRAC_BITS-1:0]         frac_t;

	localparam logic [1:0] FUNC_BEGIN = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_LAG   = 2'd2;
	localparam logic [1:0] FUNC_MODE  = 2'd3;

	localparam logic [1:0] MODE_MENU     = 2'd0;
	localparam logic [1:0] MODE_STD3D    = 2'd1;
	localparam logic [1:0] MODE_STD2D    = 2'd2;
	localparam logic [1:0] MODE_MENU_ALT = 2'd3;

	localparam frac_t ONE_Q16     = 17'd65536;
	localparam frac_t INERTIA_RST = 17'd6554;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] mode;
		val_t       goal_tx;
		val_t       goal_ty;
		val_t       goal_tz;
		val_t       goal_pitch;
		val_t       goal_yaw;
		val_t       goal_roll;
		tim_t       span;
		tim_t       delta_time;
	} pose_req_t;

	typedef struct packed {
		val_t shown_tx;
		val_t shown_ty;
		val_t shown_tz;
		val_t shown_pitch;
		val_t shown_yaw;
		val_t shown_roll;
		logic moving;
	} pose_rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
		logic fbit;
	} lane_ctl_t;

	// Preset pose value for one channel (menu, standard 3D, standard 2D).
	function automatic val_t preset_val(input logic [1:0] mode, input logic [2:0] ch);
		val_t v;
		v = '0;
		case (mode)
			MODE_STD3D: begin
				if (ch == 3'd2) v = VALUE_BITS'(-81920);
			end
			MODE_STD2D: begin
				if (ch == 3'd0) v = VALUE_BITS'(22938);
				if (ch == 3'd2) v = VALUE_BITS'(-98304);
			end
			default: begin
				if (ch == 3'd0) v = VALUE_BITS'(27034);
				if (ch == 3'd2) v = VALUE_BITS'(-131072);
				if (ch == 3'd3) v = VALUE_BITS'(294912);
			end
		endcase
		return v;
	endfunction

endpackage

>>> hdl/pose_transition_animator.sv
// Begin, set mode, idle tick and blocked lag go straight to the done state, and the
// result is registered from there once the output register is free. A lag step runs blend,
//   write-back and done; a running tick runs divide, square, cube, blend, write-back, done.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset: arst_n low clears control, loads the menu pose into aim and display,
//   zeroes timing state and sets inertia to 6554.
module pose_transition_animator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  pta_pkg::pose_req_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output pta_pkg::pose_rsp_t   rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [16:0]          cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_SQR   = 3'd2;
	localparam logic [2:0] S_CUBE  = 3'd3;
	localparam logic [2:0] S_BLEND = 3'd4;
	localparam logic [2:0] S_WB    = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic [4:0]          cnt_q;
	logic [16:0]         inertia_q;
	pta_pkg::val_t       aim_q   [pta_pkg::CHANNELS];
	pta_pkg::val_t       shown_q [pta_pkg::CHANNELS];
	pta_pkg::val_t       start_q [pta_pkg::CHANNELS];
	pta_pkg::val_t       end_q   [pta_pkg::CHANNELS];
	pta_pkg::tim_t       elapsed_q;
	pta_pkg::tim_t       length_q;
	logic                running_q;
	logic [1:0]          view_mode_q;
	logic                lag_q;

	// serial datapath registers
	pta_pkg::tim_t       rem_q;
	logic [15:0]         p_q;
	logic [31:0]         mcand_q;
	logic [15:0]         mplier_q;
	logic [31:0]         m1_q;
	logic [17:0]         q_q;
	logic [32:0]         acc2_q;
	pta_pkg::frac_t      frac_q;

	logic                rsp_valid_q;
	pta_pkg::pose_rsp_t  rsp_q;

	pta_pkg::val_t       goal   [pta_pkg::CHANNELS];
	pta_pkg::val_t       lane_a [pta_pkg::CHANNELS];
	pta_pkg::val_t       lane_b [pta_pkg::CHANNELS];
	pta_pkg::val_t       lane_r [pta_pkg::CHANNELS];
	pta_pkg::lane_ctl_t  lctl;

	logic                accept;
	logic [pta_pkg::TIME_BITS:0]   el_sum;
	pta_pkg::tim_t                 el_new;
	logic [pta_pkg::TIME_BITS:0]   rem2;
	logic                          rem_ge;
	logic [33:0]                   cube_sum;
	pta_pkg::frac_t                lag_frac;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign goal[0] = req.goal_tx;
	assign goal[1] = req.goal_ty;
	assign goal[2] = req.goal_tz;
	assign goal[3] = req.goal_pitch;
	assign goal[4] = req.goal_yaw;
	assign goal[5] = req.goal_roll;

	// saturating elapsed-time accumulate
	assign el_sum = {1'b0, elapsed_q} + {1'b0, req.delta_time};
	assign el_new = el_sum[pta_pkg::TIME_BITS] ? '1 : el_sum[pta_pkg::TIME_BITS-1:0];

	// restoring divide step: one phase bit per cycle
	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = (rem2 >= {1'b0, length_q});

	// cube step: shift out one product bit per multiplier bit
	assign cube_sum = {1'b0, acc2_q} + (q_q[0] ? {2'b0, m1_q} : 34'd0);

	assign lag_frac = (inertia_q > pta_pkg::ONE_Q16) ? pta_pkg::ONE_Q16 : inertia_q;

	always_comb begin
		lctl.load = accept && (req.func == pta_pkg::FUNC_LAG) && !running_q;
		lctl.load = lctl.load || ((state_q == S_CUBE) && (cnt_q == 5'd17));
		lctl.step = (state_q == S_BLEND);
		lctl.last = (cnt_q == 5'd16);
		lctl.fbit = frac_q[0];
	end

	// lag blends display toward aim; a tick blends start toward end
	for (genvar c = 0; c < pta_pkg::CHANNELS; c++) begin : g_lane
		assign lane_a[c] = (state_q == S_IDLE) ? shown_q[c] : start_q[c];
		assign lane_b[c] = (state_q == S_IDLE) ? aim_q[c]   : end_q[c];

		pta_blend_lane u_lane (
			.clk (clk),
			.ctl (lctl),
			.a   (lane_a[c]),
			.b   (lane_b[c]),
			.res (lane_r[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q <= pta_pkg::INERTIA_RST;
		end else if (cfg_valid && cfg_ready) begin
			inertia_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			elapsed_q   <= '0;
			length_q    <= '0;
			running_q   <= 1'b0;
			view_mode_q <= pta_pkg::MODE_MENU;
			lag_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int c = 0; c < pta_pkg::CHANNELS; c++) begin
				aim_q[c]   <= pta_pkg::preset_val(pta_pkg::MODE_MENU, 3'(c));
				shown_q[c] <= pta_pkg::preset_val(pta_pkg::MODE_MENU, 3'(c));
				start_q[c] <= '0;
				end_q[c]   <= '0;
			end
		end else begin
			// drop the held result once it is taken
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						cnt_q   <= '0;
						case (req.func)
							pta_pkg::FUNC_BEGIN: begin
								elapsed_q <= '0;
								length_q  <= req.span;
								running_q <= (req.span != '0);
								for (int c = 0; c < pta_pkg::CHANNELS; c++) begin
									start_q[c] <= shown_q[c];
									end_q[c]   <= goal[c];
									if (req.span == '0) begin
										aim_q[c]   <= goal[c];
										shown_q[c] <= goal[c];
									end else begin
										aim_q[c] <= shown_q[c];
									end
								end
							end
							pta_pkg::FUNC_TICK: begin
								if (running_q) begin
									if (el_new >= length_q) begin
										elapsed_q <= length_q;
										running_q <= 1'b0;
										for (int c = 0; c < pta_pkg::CHANNELS; c++) begin
											aim_q[c]   <= end_q[c];
											shown_q[c] <= end_q[c];
										end
									end else begin
										elapsed_q <= el_new;
										rem_q     <= el_new;
										p_q       <= '0;
										lag_q     <= 1'b0;
										state_q   <= S_DIV;
									end
								end
							end
							pta_pkg::FUNC_LAG: begin
								if (!running_q) begin
									frac_q  <= lag_frac;
									lag_q   <= 1'b1;
									state_q <= S_BLEND;
								end
							end
							default: begin
								view_mode_q <= (req.mode == pta_pkg::MODE_MENU_ALT)
									? pta_pkg::MODE_MENU : req.mode;
								for (int c = 0; c < pta_pkg::CHANNELS; c++) begin
									aim_q[c] <= pta_pkg::preset_val(req.mode, 3'(c));
								end
							end
						endcase
					end
				end
				S_DIV: begin
					// advance one quotient bit
					rem_q <= rem_ge ? pta_pkg::TIME_BITS'(rem2 - {1'b0, length_q})
					                : rem2[pta_pkg::TIME_BITS-1:0];
					p_q   <= {p_q[14:0], rem_ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						cnt_q    <= '0;
						mcand_q  <= {16'd0, p_q[14:0], rem_ge};
						mplier_q <= {p_q[14:0], rem_ge};
						m1_q     <= '0;
						state_q  <= S_SQR;
					end
				end
				S_SQR: begin
					m1_q     <= m1_q + (mplier_q[0] ? mcand_q : 32'd0);
					mcand_q  <= {mcand_q[30:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[15:1]};
					cnt_q    <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						cnt_q   <= '0;
						q_q     <= 18'd196608 - {1'b0, p_q, 1'b0};
						acc2_q  <= '0;
						state_q <= S_CUBE;
					end
				end
				S_CUBE: begin
					if (cnt_q == 5'd17) begin
						// eased phase is the product shifted down by 32
						frac_q  <= cube_sum[31:15];
						cnt_q   <= '0;
						state_q <= S_BLEND;
					end else begin
						acc2_q <= cube_sum[33:1];
						q_q    <= {1'b0, q_q[17:1]};
						cnt_q  <= cnt_q + 5'd1;
					end
				end
				S_BLEND: begin
					frac_q <= {1'b0, frac_q[16:1]};
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						cnt_q   <= '0;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					for (int c = 0; c < pta_pkg::CHANNELS; c++) begin
						shown_q[c] <= lane_r[c];
						if (!lag_q) aim_q[c] <= lane_r[c];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.shown_tx    <= shown_q[0];
			rsp_q.shown_ty    <= shown_q[1];
			rsp_q.shown_tz    <= shown_q[2];
			rsp_q.shown_pitch <= shown_q[3];
			rsp_q.shown_yaw   <= shown_q[4];
			rsp_q.shown_roll  <= shown_q[5];
			rsp_q.moving      <= running_q;
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted item did not start work");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < length_q))
		else $error("divider remainder out of range");

	a_running_length: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (length_q != '0))
		else $error("transition running with zero length");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside completion");
`endif

endmodule

>>> hdl/pta_blend_lane.sv
// Bit-serial a + floor((b - a) * f / 2^16), fraction bits fed LSB first.
module pta_blend_lane (
	input  logic                    clk,
	input  pta_pkg::lane_ctl_t      ctl,
	input  pta_pkg::val_t           a,
	input  pta_pkg::val_t           b,
	output pta_pkg::val_t           res
);

	logic signed [pta_pkg::VALUE_BITS:0]   d_q;
	logic signed [pta_pkg::VALUE_BITS+2:0] acc_q;
	pta_pkg::val_t                         a_q;
	logic signed [pta_pkg::VALUE_BITS+2:0] sum;

	assign sum = acc_q + (ctl.fbit ? (pta_pkg::VALUE_BITS+3)'(d_q) : '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q   <= (pta_pkg::VALUE_BITS+1)'(b) - (pta_pkg::VALUE_BITS+1)'(a);
			a_q   <= a;
			acc_q <= '0;
		end else if (ctl.step) begin
			// drop one product bit per step, except on the top fraction bit
			acc_q <= ctl.last ? sum : (sum >>> 1);
		end
	end

	assign res = pta_pkg::VALUE_BITS'(a_q + acc_q[pta_pkg::VALUE_BITS-1:0]);

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	pta_pkg::pose_req_t req;
	logic rsp_valid;
	logic rsp_stall;
	pta_pkg::pose_rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [16:0] cfg_data;

	pose_transition_animator uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow copy of the animator state
	logic signed [63:0] aim_q[6], disp_q[6], from_q[6], goal_q[6];
	logic [63:0] run_time, run_len;
	logic in_motion;
	logic [16:0] lag_frac;

	pta_pkg::pose_req_t pending_reqs[$];
	pta_pkg::pose_rsp_t expected_poses[$];
	int errors;
	int idle_cycles;
	int sent_count;
	int got_count;
	bit hold_sender;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [63:0] floor16(input logic signed [63:0] x);
		return x >>> 16;
	endfunction

	function automatic logic signed [63:0] mix(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic [63:0] f);
		return a + floor16((b - a) * $signed(f));
	endfunction

	function automatic logic signed [63:0] preset_of(input logic [1:0] m, input int c);
		logic signed [63:0] v;
		v = '0;
		if (m == pta_pkg::MODE_STD3D) begin
			if (c == 2) v = -64'sd81920;
		end else if (m == pta_pkg::MODE_STD2D) begin
			if (c == 0) v = 64'sd22938;
			if (c == 2) v = -64'sd98304;
		end else begin
			if (c == 0) v = 64'sd27034;
			if (c == 2) v = -64'sd131072;
			if (c == 3) v = 64'sd294912;
		end
		return v;
	endfunction

	task automatic reset_pose_model();
		for (int c = 0; c < 6; c++) begin
			aim_q[c] = preset_of(pta_pkg::MODE_MENU, c);
			disp_q[c] = aim_q[c];
			from_q[c] = '0;
			goal_q[c] = '0;
		end
		run_time = '0;
		run_len = '0;
		in_motion = 1'b0;
		lag_frac = pta_pkg::INERTIA_RST;
	endtask

	// Advance the shadow state by one item and queue the pose it shows
	task automatic predict_pose(input pta_pkg::pose_req_t r);
		logic signed [63:0] g[6];
		logic [63:0] p, s, f;
		pta_pkg::pose_rsp_t e;
		g[0] = 64'(r.goal_tx); g[1] = 64'(r.goal_ty); g[2] = 64'(r.goal_tz);
		g[3] = 64'(r.goal_pitch); g[4] = 64'(r.goal_yaw); g[5] = 64'(r.goal_roll);
		case (r.func)
			pta_pkg::FUNC_BEGIN: begin
				for (int c = 0; c < 6; c++) begin
					from_q[c] = disp_q[c];
					aim_q[c] = disp_q[c];
					goal_q[c] = g[c];
				end
				run_time = '0;
				run_len = 64'(r.span);
				if (run_len == 0) begin
					for (int c = 0; c < 6; c++) begin
						aim_q[c] = goal_q[c];
						disp_q[c] = goal_q[c];
					end
					in_motion = 1'b0;
				end else in_motion = 1'b1;
			end
			pta_pkg::FUNC_TICK: begin
				if (in_motion) begin
					run_time = run_time + 64'(r.delta_time);
					if (run_time > 64'hFFFFFF) run_time = 64'hFFFFFF;
					if (run_len == 0 || run_time >= run_len) begin
						for (int c = 0; c < 6; c++) begin
							aim_q[c] = goal_q[c];
							disp_q[c] = goal_q[c];
						end
						run_time = run_len;
						in_motion = 1'b0;
					end else begin
						p = (run_time << 16) / run_len;
						s = (p * p * (64'd196608 - 64'd2 * p)) >> 32;
						for (int c = 0; c < 6; c++) begin
							aim_q[c] = mix(from_q[c], goal_q[c], s);
							disp_q[c] = aim_q[c];
						end
					end
				end
			end
			pta_pkg::FUNC_LAG: begin
				if (!in_motion) begin
					f = (lag_frac > 17'd65536) ? 64'd65536 : 64'(lag_frac);
					for (int c = 0; c < 6; c++) disp_q[c] = mix(disp_q[c], aim_q[c], f);
				end
			end
			default: begin
				for (int c = 0; c < 6; c++) aim_q[c] = preset_of(r.mode, c);
			end
		endcase
		e.shown_tx = disp_q[0][23:0]; e.shown_ty = disp_q[1][23:0];
		e.shown_tz = disp_q[2][23:0]; e.shown_pitch = disp_q[3][23:0];
		e.shown_yaw = disp_q[4][23:0]; e.shown_roll = disp_q[5][23:0];
		e.moving = in_motion;
		expected_poses.push_back(e);
	endtask

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic pta_pkg::pose_req_t rand_req(input logic [1:0] fn);
		pta_pkg::pose_req_t r;
		r.func = fn;
		r.mode = 2'($urandom_range(0, 3));
		r.goal_tx = 24'($urandom); r.goal_ty = 24'($urandom); r.goal_tz = 24'($urandom);
		r.goal_pitch = 24'($urandom); r.goal_yaw = 24'($urandom);
		r.goal_roll = 24'($urandom);
		// mostly short spans and ticks so transitions take several steps
		r.span = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
		r.delta_time = ($urandom_range(0, 19) == 0) ? 24'($urandom)
			: 24'($urandom_range(0, 1500));
		return r;
	endfunction

	// Driver: hold the transfer until accepted, then pause a random gap
	int drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			drv_gap = 0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_pose(req);
				sent_count++;
				drv_gap = gap_len();
			end
			if (req_valid && req_stall) begin
				// hold the stalled payload
			end else if (drv_gap > 0) begin
				drv_gap--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && !hold_sender) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else req_valid <= 1'b0;
		end
	end

	// Monitor: compare each result transfer against the oldest expected pose
	int mon_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b1;
			mon_gap = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got_count++;
				if (expected_poses.size() == 0) begin
					$display("%0t: unexpected result %h", $time, rsp);
					errors++;
				end else begin
					pta_pkg::pose_rsp_t e;
					e = expected_poses.pop_front();
					if (e.shown_tx !== rsp.shown_tx) begin
						$display("%0t: shown_tx exp %h got %h", $time, e.shown_tx, rsp.shown_tx);
						errors++;
					end
					if (e.shown_ty !== rsp.shown_ty) begin
						$display("%0t: shown_ty exp %h got %h", $time, e.shown_ty, rsp.shown_ty);
						errors++;
					end
					if (e.shown_tz !== rsp.shown_tz) begin
						$display("%0t: shown_tz exp %h got %h", $time, e.shown_tz, rsp.shown_tz);
						errors++;
					end
					if (e.shown_pitch !== rsp.shown_pitch) begin
						$display("%0t: shown_pitch exp %h got %h", $time, e.shown_pitch,
							rsp.shown_pitch);
						errors++;
					end
					if (e.shown_yaw !== rsp.shown_yaw) begin
						$display("%0t: shown_yaw exp %h got %h", $time, e.shown_yaw, rsp.shown_yaw);
						errors++;
					end
					if (e.shown_roll !== rsp.shown_roll) begin
						$display("%0t: shown_roll exp %h got %h", $time, e.shown_roll,
							rsp.shown_roll);
						errors++;
					end
					if (e.moving !== rsp.moving) begin
						$display("%0t: moving exp %b got %b", $time, e.moving, rsp.moving);
						errors++;
					end
				end
			end
			if (mon_gap > 0) begin
				mon_gap--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				mon_gap = gap_len();
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_poses.size() > 0 || req_valid) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_inertia(input logic [16:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		lag_frac = v;
	endtask

	task automatic add_item(input pta_pkg::pose_req_t r);
		pending_reqs.push_back(r);
	endtask

	// A well-formed animation: begin, a run of ticks, then some lag steps or mode changes
	task automatic add_sequence();
		int n;
		add_item(rand_req(pta_pkg::FUNC_BEGIN));
		n = $urandom_range(2, 10);
		for (int i = 0; i < n; i++) add_item(rand_req(pta_pkg::FUNC_TICK));
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++)
			add_item(rand_req($urandom_range(0, 4) == 0 ? pta_pkg::FUNC_MODE
				: pta_pkg::FUNC_LAG));
	endtask

	initial begin
		pta_pkg::pose_req_t r;
		logic [16:0] inertia_set[4];
		inertia_set = '{17'd0, 17'd65536, 17'h1FFFF, 17'd30000};
		errors = 0;
		sent_count = 0;
		got_count = 0;
		idle_cycles = 0;
		hold_sender = 0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		reset_pose_model();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lag at reset inertia, presets, extreme goals, zero span
		r = '0;
		r.func = pta_pkg::FUNC_LAG; add_item(r);
		r.func = pta_pkg::FUNC_TICK; r.delta_time = 24'hFFFFFF; add_item(r);
		for (int m = 0; m < 4; m++) begin
			r.func = pta_pkg::FUNC_MODE; r.mode = 2'(m); add_item(r);
			r.func = pta_pkg::FUNC_LAG; add_item(r);
		end
		r = '0;
		r.func = pta_pkg::FUNC_BEGIN;
		r.goal_tx = 24'h7FFFFF; r.goal_ty = 24'h800000; r.goal_tz = 24'h7FFFFF;
		r.goal_pitch = 24'h800000; r.goal_yaw = 24'hFFFFFF; r.goal_roll = 24'h000001;
		r.span = '0; add_item(r);
		r.goal_tx = 24'h800000; r.goal_ty = 24'h7FFFFF; r.span = 24'hFFFFFF; add_item(r);
		r.func = pta_pkg::FUNC_LAG; add_item(r);
		r.func = pta_pkg::FUNC_MODE; r.mode = pta_pkg::MODE_STD3D; add_item(r);
		r.func = pta_pkg::FUNC_TICK; r.delta_time = 24'h800000; add_item(r);
		r.delta_time = 24'hFFFFFF; add_item(r);
		r.func = pta_pkg::FUNC_BEGIN; r.span = 24'd1; add_item(r);
		r.func = pta_pkg::FUNC_TICK; r.delta_time = '0; add_item(r);
		r.delta_time = 24'd1; add_item(r);
		r.func = pta_pkg::FUNC_LAG; add_item(r);
		drain();

		// Random phases across inertia settings, extremes included
		for (int ph = 0; ph < 4; ph++) begin
			write_inertia(inertia_set[ph]);
			while (pending_reqs.size() < 110) begin
				if ($urandom_range(0, 4) == 0) add_item(rand_req(2'($urandom_range(0, 3))));
				else add_sequence();
			end
			if (ph == 1) begin
				// pause the sender until the block has drained
				hold_sender = 1;
				while (pending_reqs.size() > 55) begin
					hold_sender = 0;
					@(posedge clk);
				end
				hold_sender = 1;
				while (expected_poses.size() > 0 || req_valid) @(posedge clk);
				hold_sender = 0;
			end
		end
		drain();

		$display("tb: %0d items sent, %0d poses checked over 4 inertia settings", sent_count,
			got_count);
		if (errors == 0 && expected_poses.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
